FILE: rtl/pbtn_pkg.sv
// ----------------------------------------------------------------------------
// pbtn_pkg
// shared types and constants for the pad button edge and auto-repeat block
// ----------------------------------------------------------------------------
`default_nettype none

package pbtn_pkg;

    // configuration register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_TRIG_THRESH = 2'd0,
        REG_REP_DELAY   = 2'd1,
        REG_REP_FAST    = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // register reset values
    localparam logic [7:0] TRIG_THRESH_RST = 8'hD3;
    localparam logic [7:0] REP_DELAY_RST   = 8'h20;
    localparam logic [7:0] REP_FAST_RST    = 8'h50;

    // button word bits driven by the analogue triggers
    localparam int unsigned TRIG_LEFT_BIT  = 2;
    localparam int unsigned TRIG_RIGHT_BIT = 6;

    // hold counter saturation and slow repeat period mask (every fourth poll)
    localparam logic [7:0] HOLD_MAX      = 8'hFF;
    localparam logic [1:0] SLOW_PER_MASK = 2'b11;

    localparam int unsigned PORT_W   = 2;
    localparam int unsigned BTN_W    = 16;
    localparam int unsigned IN_DW    = 64;
    localparam int unsigned IN_UW    = 3;
    localparam int unsigned OUT_DW   = 96;
    localparam int unsigned OUT_UW   = 3;

endpackage

`default_nettype wire

FILE: rtl/pad_button_edge_and_autorepeat.sv
// ----------------------------------------------------------------------------
// pad_button_edge_and_autorepeat
// game-pad poll decoder with button edge detection and typematic auto-repeat
// ----------------------------------------------------------------------------
// One poll response word enters per cycle on the slave stream and one result
// word leaves per word accepted, in order. Each word is first captured in an
// input register, then the button word, trigger bits, pressed and repeat masks
// are formed in one pass against the per-port history and hold counter, which
// are updated at the same edge that loads the result register. A second word
// for the same port in the next cycle thus sees the updated history. Sustained
// rate is one word per cycle, limited only by downstream tready. Responses
// flagged as no-response, or for a port at or beyond PORTS, leave the history
// untouched and give present=0 with all data fields zero. Thresholds and repeat
// timings come from three APB registers (0x0 trigger threshold, 0x4 repeat
// delay, 0x8 fast repeat start).
// ----------------------------------------------------------------------------
`default_nettype none

module pad_button_edge_and_autorepeat
    import pbtn_pkg::*;
#(
    parameter int unsigned PORTS = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // poll response stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // byte_buttons_high, byte_buttons_low, byte_trigger_left, byte_trigger_right,
    // byte_four, byte_five, byte_six, byte_seven
    input  wire logic [IN_DW-1:0]    s_axis_tdata,
    // port, no_response
    input  wire logic [IN_UW-1:0]    s_axis_tuser,

    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // buttons_now, buttons_pressed, buttons_repeat, trigger_left, trigger_right,
    // stick_a_x, stick_a_y, stick_b_x, stick_b_y
    output logic [OUT_DW-1:0]        m_axis_tdata,
    // out_port, present
    output logic [OUT_UW-1:0]        m_axis_tuser,

    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int unsigned IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // configuration registers
    logic [7:0] r_trig_thresh;
    logic [7:0] r_rep_delay;
    logic [7:0] r_rep_fast;
    t_reg_idx   reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_thresh <= TRIG_THRESH_RST;
            r_rep_delay   <= REP_DELAY_RST;
            r_rep_fast    <= REP_FAST_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TRIG_THRESH: r_trig_thresh <= pwdata[7:0];
                REG_REP_DELAY:   r_rep_delay   <= pwdata[7:0];
                REG_REP_FAST:    r_rep_fast    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRIG_THRESH: prdata = {24'd0, r_trig_thresh};
            REG_REP_DELAY:   prdata = {24'd0, r_rep_delay};
            REG_REP_FAST:    prdata = {24'd0, r_rep_fast};
            default:         prdata = '0;
        endcase
    end

    // handshake: input register feeds result register
    logic             r_s1_vld;
    logic [IN_DW-1:0] r_s1_data;
    logic [IN_UW-1:0] r_s1_user;
    logic             r_out_vld;
    logic             advance;

    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || advance;
    assign m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_data <= s_axis_tdata;
            r_s1_user <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_s1_vld;
        end
    end

    // unpack the captured response
    logic [PORT_W-1:0] s1_port;
    logic              s1_nr;
    logic [7:0]        b_hi, b_lo, b_tl, b_tr, b_4, b_5, b_6, b_7;

    assign s1_port = r_s1_user[PORT_W-1:0];
    assign s1_nr   = r_s1_user[PORT_W];
    assign b_hi    = r_s1_data[7:0];
    assign b_lo    = r_s1_data[15:8];
    assign b_tl    = r_s1_data[23:16];
    assign b_tr    = r_s1_data[31:24];
    assign b_4     = r_s1_data[39:32];
    assign b_5     = r_s1_data[47:40];
    assign b_6     = r_s1_data[55:48];
    assign b_7     = r_s1_data[63:56];

    // per-port history
    logic [BTN_W-1:0] r_last [PORTS];
    logic [7:0]       r_hold [PORTS];

    logic             port_ok;
    logic             present;
    logic [IDX_W-1:0] idx;
    logic [BTN_W-1:0] prev, now, pressed, held, rep;
    logic [7:0]       hold_cur, n_hold;
    logic             fire;

    assign port_ok = (32'(s1_port) < PORTS);
    assign present = port_ok && !s1_nr;
    assign idx     = IDX_W'(s1_port);

    always_comb begin
        prev     = present ? r_last[idx] : '0;
        hold_cur = present ? r_hold[idx] : '0;

        now = {b_hi, b_lo};
        if (b_tl >= r_trig_thresh) now[TRIG_LEFT_BIT]  = 1'b1;
        if (b_tr >= r_trig_thresh) now[TRIG_RIGHT_BIT] = 1'b1;

        pressed = now & ~prev;
        held    = now & prev;

        // hold counter steps on any held bit and saturates
        if (held != '0) begin
            n_hold = (hold_cur == HOLD_MAX) ? HOLD_MAX : hold_cur + 8'd1;
        end else begin
            n_hold = '0;
        end

        // slow repeat on every fourth poll past the delay, fast repeat every poll
        fire = (held != '0) && (n_hold >= r_rep_delay)
               && ((n_hold >= r_rep_fast) || ((n_hold & {6'd0, SLOW_PER_MASK}) == 8'd0));

        rep = (fire ? held : '0) | pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                r_last[p] <= '0;
                r_hold[p] <= '0;
            end
        end else if (advance && r_s1_vld && present) begin
            r_last[idx] <= now;
            r_hold[idx] <= n_hold;
        end
    end

    // result register
    logic [OUT_DW-1:0] r_out_data;
    logic [OUT_UW-1:0] r_out_user;

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_vld) begin
            r_out_user <= {present, s1_port};
            if (present) begin
                r_out_data <= {b_6, b_7, b_4, b_5, b_tr, b_tl, rep, pressed, now};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_user;

    // checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[PORT_W]) |-> (m_axis_tdata == '0))
        else $error("absent port result carries data");

    a_pressed_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (((m_axis_tdata[31:16] & ~m_axis_tdata[15:0]) == '0)
                        && ((m_axis_tdata[31:16] & ~m_axis_tdata[47:32]) == '0)))
        else $error("pressed bits outside now or repeat");

    a_repeat_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[47:32] & ~m_axis_tdata[15:0]) == '0))
        else $error("repeat bits outside current word");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

endmodule

`default_nettype wire

FILE: verif/tb_pad_button_edge_and_autorepeat.sv
// ----------------------------------------------------------------------------
// tb_pad_button_edge_and_autorepeat
// stream-level check of the pad button decoder with edge and auto-repeat
// ----------------------------------------------------------------------------
// Poll responses are queued by the stimulus process and presented by a driver
// on the falling edge; a monitor on the rising edge decodes every accepted
// poll with its own per-port history and hold counters, and compares each
// result word field by field against the oldest decoded report. Phases change
// the thresholds and repeat timings through the APB port while the block is
// drained, and vary source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_pad_button_edge_and_autorepeat;
    import pbtn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PORTS      = 4;
    localparam int DRAIN_CYCLES   = 8;     // drain margin past the input and result registers
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [7:0] HOLD_LIMIT = 8'hFF;

    // one poll response as it arrives from a controller port
    typedef struct packed {
        logic [1:0] port;
        logic       no_resp;
        logic [7:0] btn_hi;
        logic [7:0] btn_lo;
        logic [7:0] trig_l;
        logic [7:0] trig_r;
        logic [7:0] axis4;
        logic [7:0] axis5;
        logic [7:0] axis6;
        logic [7:0] axis7;
    } t_pad_poll;

    // one decoded report as it leaves the block
    typedef struct packed {
        logic [1:0]  port;
        logic        present;
        logic [15:0] btn_now;
        logic [15:0] btn_pressed;
        logic [15:0] btn_repeat;
        logic [7:0]  trig_l;
        logic [7:0]  trig_r;
        logic [7:0]  stick_ax;
        logic [7:0]  stick_ay;
        logic [7:0]  stick_bx;
        logic [7:0]  stick_by;
    } t_pad_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata;
    logic [IN_UW-1:0]  s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [OUT_UW-1:0] m_axis_tuser;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pad_button_edge_and_autorepeat #(
        .PORTS(NUM_PORTS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // btn_hi, btn_lo, trig_l, trig_r, axis4, axis5, axis6, axis7
        .s_axis_tdata  (s_axis_tdata),
        // port, no_resp
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // now, pressed, repeat, trig_l, trig_r, stick a x/y, stick b x/y
        .m_axis_tdata  (m_axis_tdata),
        // port, present
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model state: registers and per-port history
    // ------------------------------------------------------------------------
    logic [7:0]  cfg_threshold = TRIG_THRESH_RST;
    logic [7:0]  cfg_delay     = REP_DELAY_RST;
    logic [7:0]  cfg_fast      = REP_FAST_RST;
    logic [15:0] last_word [NUM_PORTS] = '{default: '0};
    logic [7:0]  hold_cnt  [NUM_PORTS] = '{default: '0};

    // chord currently held on each port by the random stimulus
    logic [15:0] chord [NUM_PORTS] = '{default: '0};

    t_pad_poll   poll_q[$];          // polls waiting for the driver
    t_pad_report pad_reports_q[$];   // decoded reports still to come out
    t_pad_poll   shown_poll;         // poll currently on the slave side

    int polls_offered  = 0;
    int polls_taken    = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // decode one accepted poll and advance that port's history
    function automatic t_pad_report decode_poll(t_pad_poll p);
        t_pad_report r;
        logic [15:0] prev_word;
        logic [15:0] held;
        logic [7:0]  cnt;
        r = '0;
        r.port = p.port;
        // silent port, or one past the configured count: history untouched
        if (p.no_resp || int'(p.port) >= NUM_PORTS)
            return r;
        prev_word = last_word[p.port];
        r.btn_now = {p.btn_hi, p.btn_lo};
        if (p.trig_l >= cfg_threshold) r.btn_now[TRIG_LEFT_BIT] = 1'b1;
        if (p.trig_r >= cfg_threshold) r.btn_now[TRIG_RIGHT_BIT] = 1'b1;
        r.btn_pressed = r.btn_now & ~prev_word;
        held = r.btn_now & prev_word;
        if (held != '0) begin
            cnt = hold_cnt[p.port];
            if (cnt != HOLD_LIMIT) cnt = cnt + 8'd1;
            hold_cnt[p.port] = cnt;
            // slow phase fires on every fourth count, fast phase on each poll
            if (cnt >= cfg_delay && (cnt >= cfg_fast || cnt[1:0] == 2'b00))
                r.btn_repeat = held;
        end else begin
            hold_cnt[p.port] = '0;
        end
        r.btn_repeat  = r.btn_repeat | r.btn_pressed;
        last_word[p.port] = r.btn_now;
        r.present  = 1'b1;
        r.trig_l   = p.trig_l;
        r.trig_r   = p.trig_r;
        r.stick_ax = p.axis5;
        r.stick_ay = p.axis4;
        r.stick_bx = p.axis7;
        r.stick_by = p.axis6;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v,
                                        logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // poll driver: changes on the falling edge, holds a word until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : poll_driver
        t_pad_poll nxt;
        if (i_rst_n) begin
            if (!s_axis_tvalid || polls_taken == polls_offered) begin
                if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = poll_q.pop_front();
                    shown_poll = nxt;
                    polls_offered++;
                    s_axis_tdata  <= {nxt.axis7, nxt.axis6, nxt.axis5, nxt.axis4,
                                      nxt.trig_r, nxt.trig_l, nxt.btn_lo, nxt.btn_hi};
                    s_axis_tuser  <= {nxt.no_resp, nxt.port};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: result check, poll decode and watchdog on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : report_monitor
        t_pad_report got;
        t_pad_report want;
        logic        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                moved = 1'b1;
                got.port        = m_axis_tuser[1:0];
                got.present     = m_axis_tuser[2];
                got.btn_now     = m_axis_tdata[15:0];
                got.btn_pressed = m_axis_tdata[31:16];
                got.btn_repeat  = m_axis_tdata[47:32];
                got.trig_l      = m_axis_tdata[55:48];
                got.trig_r      = m_axis_tdata[63:56];
                got.stick_ax    = m_axis_tdata[71:64];
                got.stick_ay    = m_axis_tdata[79:72];
                got.stick_bx    = m_axis_tdata[87:80];
                got.stick_by    = m_axis_tdata[95:88];
                if (pad_reports_q.size() == 0) begin
                    $display("%0t: result word with none outstanding, got %h %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pad_reports_q.pop_front();
                    check_field("out_port", 16'(want.port), 16'(got.port));
                    check_field("present", 16'(want.present), 16'(got.present));
                    check_field("buttons_now", want.btn_now, got.btn_now);
                    check_field("buttons_pressed", want.btn_pressed, got.btn_pressed);
                    check_field("buttons_repeat", want.btn_repeat, got.btn_repeat);
                    check_field("trigger_left", 16'(want.trig_l), 16'(got.trig_l));
                    check_field("trigger_right", 16'(want.trig_r), 16'(got.trig_r));
                    check_field("stick_a_x", 16'(want.stick_ax), 16'(got.stick_ax));
                    check_field("stick_a_y", 16'(want.stick_ay), 16'(got.stick_ay));
                    check_field("stick_b_x", 16'(want.stick_bx), 16'(got.stick_bx));
                    check_field("stick_b_y", 16'(want.stick_by), 16'(got.stick_by));
                end
            end
            // decode after the check so a same-edge result cannot match it
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                moved = 1'b1;
                polls_taken++;
                pad_reports_q.push_back(decode_poll(shown_poll));
            end
            if (!moved && (poll_q.size() != 0 || polls_taken != polls_offered
                           || pad_reports_q.size() != 0)) begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end else begin
                idle_cycles = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_poll(logic [1:0] port, logic no_resp, logic [15:0] word,
                              logic [7:0] tl, logic [7:0] tr, logic [31:0] sticks);
        t_pad_poll p;
        p.port    = port;
        p.no_resp = no_resp;
        {p.btn_hi, p.btn_lo} = word;
        p.trig_l  = tl;
        p.trig_r  = tr;
        {p.axis7, p.axis6, p.axis5, p.axis4} = sticks;
        poll_q.push_back(p);
    endtask

    // trigger levels cluster on the threshold edge
    function automatic logic [7:0] trigger_level();
        case ($urandom_range(3))
            0:       return cfg_threshold;
            1:       return cfg_threshold - 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // chords held across many polls, with presses, releases and noise words
    task automatic queue_random_polls(int count);
        logic [1:0]  port;
        logic [15:0] word;
        for (int k = 0; k < count; k++) begin
            port = 2'($urandom_range(NUM_PORTS - 1));
            word = chord[port];
            case ($urandom_range(19))
                0:       chord[port] = '0;                    // full release
                1, 2:    chord[port] = 16'($urandom);         // new chord
                3, 4:    chord[port] = chord[port] ^ (16'd1 << $urandom_range(15));
                5:       word = 16'($urandom);                // one-off glitch word
                default: ;
            endcase
            if ($urandom_range(19) != 5) word = chord[port];
            queue_poll(port, $urandom_range(19) == 0, word, trigger_level(),
                       trigger_level(), $urandom);
        end
    endtask

    // one chord held on one port for a long run
    task automatic queue_hold_run(logic [1:0] port, logic [15:0] word, int count);
        for (int k = 0; k < count; k++)
            queue_poll(port, 1'b0, word, trigger_level(), trigger_level(), $urandom);
    endtask

    task automatic wait_drained();
        while (poll_q.size() != 0 || polls_taken != polls_offered
               || pad_reports_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // apb write: setup then access, register taken when pready is seen
    task automatic write_reg(t_reg_idx idx, logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TRIG_THRESH: cfg_threshold = val;
            REG_REP_DELAY:   cfg_delay     = val;
            REG_REP_FAST:    cfg_fast      = val;
            default:         ;               // unmapped, write dropped
        endcase
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset settings, no idling
        set_idling(0, 0);
        queue_poll(2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 32'h0000_0000);
        queue_poll(2'd0, 1'b0, 16'hFFFF, 8'd255, 8'd255, 32'hFFFF_FFFF);
        queue_poll(2'd0, 1'b0, 16'hFFFF, 8'd255, 8'd255, 32'h1234_5678);   // held
        queue_poll(2'd1, 1'b0, 16'h0000, 8'd211, 8'd210, 32'h8040_2010);   // left at edge
        queue_poll(2'd1, 1'b0, 16'h0000, 8'd210, 8'd211, 32'h0102_0408);   // right at edge
        queue_poll(2'd2, 1'b1, 16'hFFFF, 8'd255, 8'd255, 32'hFFFF_FFFF);   // silent port
        queue_poll(2'd3, 1'b0, 16'h8001, 8'd0, 8'd0, 32'hA5A5_5A5A);
        queue_poll(2'd3, 1'b1, 16'h0000, 8'd211, 8'd211, 32'h0000_0000);   // history kept
        queue_poll(2'd3, 1'b0, 16'h8001, 8'd0, 8'd0, 32'h5A5A_A5A5);       // still held
        queue_poll(2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 32'h0000_0000);       // release all
        queue_poll(2'd0, 1'b0, 16'h0044, 8'd0, 8'd0, 32'h0000_0000);
        queue_poll(2'd0, 1'b0, 16'h0000, 8'd255, 8'd255, 32'h0000_0000);   // same via triggers
        queue_poll(2'd2, 1'b0, 16'h7FFE, 8'd254, 8'd212, 32'hFFFF_0000);
        queue_poll(2'd2, 1'b0, 16'h0000, 8'd0, 8'd0, 32'h0000_0000);
        queue_hold_run(2'd1, 16'h0100, 8);
        wait_drained();

        // mid settings, slow then fast repeat reached quickly
        write_reg(REG_TRIG_THRESH, 8'h80);
        write_reg(REG_REP_DELAY, 8'd8);
        write_reg(REG_REP_FAST, 8'd20);
        queue_random_polls(150);
        wait_drained();

        // lower extremes: any held bit repeats on every poll
        write_reg(REG_TRIG_THRESH, 8'h00);
        write_reg(REG_REP_DELAY, 8'h00);
        write_reg(REG_REP_FAST, 8'h00);
        write_reg(REG_UNUSED, 8'h5A);
        set_idling(46, 0);
        queue_random_polls(200);
        wait_drained();

        // upper extremes: repeat only once the hold counter saturates
        write_reg(REG_TRIG_THRESH, 8'hFF);
        write_reg(REG_REP_DELAY, 8'hFF);
        write_reg(REG_REP_FAST, 8'hFF);
        set_idling(0, 46);
        queue_hold_run(2'd2, 16'h1234 | 16'($urandom_range(16'hFFFF, 16'h0001)), 280);
        queue_random_polls(50);
        wait_drained();

        // slow repeat only, fast start beyond the delay
        write_reg(REG_TRIG_THRESH, 8'(8'd100 + $urandom_range(100)));
        write_reg(REG_REP_DELAY, 8'd4);
        write_reg(REG_REP_FAST, 8'hFF);
        write_reg(REG_UNUSED, 8'hFF);
        set_idling(16, 16);
        queue_random_polls(150);
        wait_drained();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
